[sv/chord_symbol_parser_assert.svh]
// assertion macros for the chord symbol parser
// depends on nothing; included by the top level only
`ifndef CHORD_SYMBOL_PARSER_ASSERT_SVH
`define CHORD_SYMBOL_PARSER_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define CSP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is held
`define CSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[sv/csp_pkg.sv]
// shared types and constants of the chord symbol parser
// no dependencies; used by csp_step, chord_symbol_parser and the testbench
package csp_pkg;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [3:0] {
    PH_START   = 4'd0,
    PH_ROOT    = 4'd1,
    PH_ACC     = 4'd2,
    PH_M       = 4'd3,
    PH_O       = 4'd4,
    PH_X       = 4'd5,
    PH_AUG     = 4'd6,
    PH_MAJ     = 4'd7,
    PH_SEV     = 4'd8,
    PH_INV     = 4'd9,
    PH_AFTER_M = 4'd10,
    PH_INV1    = 4'd11,
    PH_INV2    = 4'd12,
    PH_DONE    = 4'd13
  } phase_t;

  typedef enum logic [3:0] {
    ERR_NONE        = 4'd0,
    ERR_ROOT        = 4'd1,
    ERR_M_O         = 4'd2,
    ERR_M_X         = 4'd3,
    ERR_AUG_MINOR   = 4'd4,
    ERR_M_NO_SEV    = 4'd5,
    ERR_SEV_MAJ7    = 4'd6,
    ERR_SEV_X       = 4'd7,
    ERR_INV_CHAR    = 4'd8,
    ERR_INV3_TRIAD  = 4'd9,
    ERR_TRAILING    = 4'd10
  } err_t;

  typedef struct packed {
    logic half;
    logic dim7;
    logic maj7;
    logic dom7;
    logic aug;
    logic dim;
    logic minor;
  } flags_t;

  typedef struct packed {
    phase_t            phase;
    err_t              err;
    logic signed [4:0] root;
    flags_t            flags;
    logic [1:0]        inv;
  } state_t;

  typedef struct packed {
    err_t              error_code;
    logic signed [4:0] root_pitch;
    logic              is_minor;
    logic              is_diminished;
    logic              is_augmented;
    logic              has_dom_seventh;
    logic              has_major_seventh;
    logic              has_dim_seventh;
    logic [1:0]        inversion_num;
    logic signed [5:0] bass_pitch;
  } result_t;

  localparam state_t STATE_RESET = '{
    phase: PH_START, err: ERR_NONE, root: 5'sd0, flags: '0, inv: 2'd0
  };

  // ascii codes of the tokens
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_FLAT  = 8'h62;
  localparam logic [7:0] CH_SHARP = 8'h23;
  localparam logic [7:0] CH_MIN   = 8'h6D;
  localparam logic [7:0] CH_DIM   = 8'h6F;
  localparam logic [7:0] CH_HALF  = 8'h78;
  localparam logic [7:0] CH_AUG   = 8'h2B;
  localparam logic [7:0] CH_MAJ   = 8'h4D;
  localparam logic [7:0] CH_SEV   = 8'h37;
  localparam logic [7:0] CH_INV   = 8'h69;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_B     = 8'h42;

endpackage

[sv/csp_step.sv]
// next-state and result logic of the chord symbol parser for one character
// depends on csp_pkg
module csp_step (
  input  csp_pkg::state_t  st,
  input  logic [7:0]       sym,
  input  logic             last,
  output csp_pkg::state_t  st_nxt,
  output csp_pkg::result_t res
);

  localparam logic signed [5:0] IV_MIN3 = 6'sd3;
  localparam logic signed [5:0] IV_MAJ3 = 6'sd4;
  localparam logic signed [5:0] IV_DIM5 = 6'sd6;
  localparam logic signed [5:0] IV_P5   = 6'sd7;
  localparam logic signed [5:0] IV_AUG5 = 6'sd8;
  localparam logic signed [5:0] IV_DIM7 = 6'sd9;
  localparam logic signed [5:0] IV_MIN7 = 6'sd10;
  localparam logic signed [5:0] IV_MAJ7 = 6'sd11;

  function automatic csp_pkg::phase_t token_slot(input logic [7:0] c);
    case (c)
      csp_pkg::CH_FLAT, csp_pkg::CH_SHARP: token_slot = csp_pkg::PH_ACC;
      csp_pkg::CH_MIN:  token_slot = csp_pkg::PH_M;
      csp_pkg::CH_DIM:  token_slot = csp_pkg::PH_O;
      csp_pkg::CH_HALF: token_slot = csp_pkg::PH_X;
      csp_pkg::CH_AUG:  token_slot = csp_pkg::PH_AUG;
      csp_pkg::CH_MAJ:  token_slot = csp_pkg::PH_MAJ;
      csp_pkg::CH_SEV:  token_slot = csp_pkg::PH_SEV;
      csp_pkg::CH_INV:  token_slot = csp_pkg::PH_INV;
      default:          token_slot = csp_pkg::PH_START;
    endcase
  endfunction

  // bit 5 flags a valid letter, low bits hold the semitone
  function automatic logic [5:0] root_code(input logic [7:0] c);
    case (c)
      csp_pkg::CH_C: root_code = {1'b1, 5'd0};
      csp_pkg::CH_D: root_code = {1'b1, 5'd2};
      csp_pkg::CH_E: root_code = {1'b1, 5'd4};
      csp_pkg::CH_F: root_code = {1'b1, 5'd5};
      csp_pkg::CH_G: root_code = {1'b1, 5'd7};
      csp_pkg::CH_A: root_code = {1'b1, 5'd9};
      csp_pkg::CH_B: root_code = {1'b1, 5'd11};
      default:       root_code = 6'd0;
    endcase
  endfunction

  csp_pkg::state_t   t;
  csp_pkg::state_t   fin;
  csp_pkg::phase_t   slot;
  logic [5:0]        rc;
  logic signed [5:0] root_x;
  logic signed [5:0] interval;

  always_comb begin
    t    = st;
    slot = token_slot(sym);
    rc   = root_code(sym);
    if (st.err == csp_pkg::ERR_NONE) begin
      case (st.phase)
        csp_pkg::PH_START, csp_pkg::PH_ROOT: begin
          if (st.phase == csp_pkg::PH_START && sym == csp_pkg::CH_STAR) begin
            t.phase = csp_pkg::PH_ROOT;
          end else if (rc[5]) begin
            t.root  = $signed(rc[4:0]);
            t.phase = csp_pkg::PH_ACC;
          end else begin
            t.err = csp_pkg::ERR_ROOT;
          end
        end
        csp_pkg::PH_AFTER_M: begin
          if (sym == csp_pkg::CH_SEV) begin
            t.flags.maj7 = 1'b1;
            t.phase      = csp_pkg::PH_SEV;
          end else begin
            t.err = csp_pkg::ERR_M_NO_SEV;
          end
        end
        csp_pkg::PH_INV1: begin
          if (sym == csp_pkg::CH_INV) begin
            t.inv   = 2'd2;
            t.phase = csp_pkg::PH_INV2;
          end else begin
            t.err = csp_pkg::ERR_INV_CHAR;
          end
        end
        csp_pkg::PH_INV2: begin
          if (sym != csp_pkg::CH_INV) begin
            t.err = csp_pkg::ERR_INV_CHAR;
          end else if (!(st.flags.dom7 || st.flags.maj7 || st.flags.dim7)) begin
            t.err = csp_pkg::ERR_INV3_TRIAD;
          end else begin
            t.inv   = 2'd3;
            t.phase = csp_pkg::PH_DONE;
          end
        end
        default: begin
          // tokens must come in slot order, each at most once
          if (slot == csp_pkg::PH_START || slot < st.phase) begin
            t.err = csp_pkg::ERR_TRAILING;
          end else begin
            case (slot)
              csp_pkg::PH_ACC: begin
                t.root  = st.root + ((sym == csp_pkg::CH_FLAT) ? -5'sd1 : 5'sd1);
                t.phase = csp_pkg::phase_t'(slot + 4'd1);
              end
              csp_pkg::PH_M: begin
                t.flags.minor = 1'b1;
                t.phase       = csp_pkg::phase_t'(slot + 4'd1);
              end
              csp_pkg::PH_O: begin
                if (st.flags.minor) begin
                  t.err = csp_pkg::ERR_M_O;
                end else begin
                  t.flags.minor = 1'b1;
                  t.flags.dim   = 1'b1;
                  t.phase       = csp_pkg::phase_t'(slot + 4'd1);
                end
              end
              csp_pkg::PH_X: begin
                if (st.flags.minor) begin
                  t.err = csp_pkg::ERR_M_X;
                end else begin
                  t.flags.minor = 1'b1;
                  t.flags.dim   = 1'b1;
                  t.flags.dom7  = 1'b1;
                  t.flags.half  = 1'b1;
                  t.phase       = csp_pkg::phase_t'(slot + 4'd1);
                end
              end
              csp_pkg::PH_AUG: begin
                if (st.flags.minor) begin
                  t.err = csp_pkg::ERR_AUG_MINOR;
                end else begin
                  t.flags.aug = 1'b1;
                  t.phase     = csp_pkg::phase_t'(slot + 4'd1);
                end
              end
              csp_pkg::PH_MAJ: begin
                t.phase = csp_pkg::PH_AFTER_M;
              end
              csp_pkg::PH_SEV: begin
                if (st.flags.maj7) begin
                  t.err = csp_pkg::ERR_SEV_MAJ7;
                end else if (st.flags.half) begin
                  t.err = csp_pkg::ERR_SEV_X;
                end else begin
                  if (st.flags.dim) t.flags.dim7 = 1'b1;
                  else t.flags.dom7 = 1'b1;
                  t.phase = csp_pkg::phase_t'(slot + 4'd1);
                end
              end
              default: begin
                t.inv   = 2'd1;
                t.phase = csp_pkg::PH_INV1;
              end
            endcase
          end
        end
      endcase
    end
  end

  // end-of-symbol checks: star alone, dangling M
  always_comb begin
    fin = t;
    if (t.err == csp_pkg::ERR_NONE) begin
      if (t.phase == csp_pkg::PH_ROOT) fin.err = csp_pkg::ERR_ROOT;
      else if (t.phase == csp_pkg::PH_AFTER_M) fin.err = csp_pkg::ERR_M_NO_SEV;
    end
  end

  always_comb begin
    root_x = {fin.root[4], fin.root};
    case (fin.inv)
      2'd1: interval = fin.flags.minor ? IV_MIN3 : IV_MAJ3;
      2'd2: interval = fin.flags.aug ? IV_AUG5 : (fin.flags.dim ? IV_DIM5 : IV_P5);
      2'd3: begin
        if (fin.flags.dom7) interval = IV_MIN7;
        else if (fin.flags.maj7) interval = IV_MAJ7;
        else if (fin.flags.dim7) interval = IV_DIM7;
        else interval = 6'sd0;
      end
      default: interval = 6'sd0;
    endcase
  end

  always_comb begin
    res            = '0;
    res.error_code = fin.err;
    if (fin.err == csp_pkg::ERR_NONE) begin
      res.root_pitch        = fin.root;
      res.is_minor          = fin.flags.minor;
      res.is_diminished     = fin.flags.dim;
      res.is_augmented      = fin.flags.aug;
      res.has_dom_seventh   = fin.flags.dom7;
      res.has_major_seventh = fin.flags.maj7;
      res.has_dim_seventh   = fin.flags.dim7;
      res.inversion_num     = fin.inv;
      res.bass_pitch        = root_x + interval;
    end
    st_nxt = last ? csp_pkg::STATE_RESET : t;
  end

endmodule

[sv/chord_symbol_parser.sv]
// top level of the chord symbol parser: input register, parse state, result register
// depends on csp_pkg, csp_step and chord_symbol_parser_assert.svh
//
// usage
//   in_*  : one ascii character per transfer in in_tdata, in_tlast marks the
//           final character of a chord symbol
//   out_* : one decoded chord per symbol, sent after its last character
//   every character advances the parse state; the first error is latched and
//   later characters of that symbol are ignored until the last one
// throughput and result path
//   one character per cycle sustained while no last character waits on a full
//   result register; out_tvalid rises once the last character has passed the input
//   register, then the parse logic into the result register
// reset
//   rst_n low empties the input and result registers and returns the parse
//   state to "expect star or root"; the state also returns there after every
//   last character
// stall
//   a non-last character is always consumed from the input register; a last
//   character waits there while the result register is full and not drained,
//   and only in that case is in_tready low; a held result keeps its tdata
`include "chord_symbol_parser_assert.svh"

module chord_symbol_parser (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [csp_pkg::IN_TDATA_W-1:0]   in_tdata,   // [7:0] symbol_char
  input  logic                             in_tlast,   // is_last
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [3:0] error_code, [8:4] root_pitch, [9] is_minor, [10] is_diminished,
  // [11] is_augmented, [12] has_dom_seventh, [13] has_major_seventh,
  // [14] has_dim_seventh, [16:15] inversion_num, [22:17] bass_pitch, [23] zero
  output logic [csp_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  // input register
  logic       in_valid_r;
  logic [7:0] in_char_r;
  logic       in_last_r;

  // parse state
  csp_pkg::state_t  state_r;
  csp_pkg::state_t  state_nxt;
  csp_pkg::result_t res;

  // result register
  logic             out_valid_r;
  csp_pkg::result_t out_res_r;

  logic out_free;
  logic proc;
  logic in_xfer;

  // result slot can take a new chord when empty or being drained this cycle
  assign out_free  = !out_valid_r || out_tready;
  // only a last character needs the result slot
  assign proc      = in_valid_r && (!in_last_r || out_free);
  assign in_tready = !in_valid_r || proc;
  assign in_xfer   = in_tvalid && in_tready;

  csp_step u_step (
    .st     (state_r),
    .sym    (in_char_r),
    .last   (in_last_r),
    .st_nxt (state_nxt),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= csp_pkg::STATE_RESET;
    end else begin
      if (in_xfer) begin
        in_valid_r <= 1'b1;
      end else if (proc) begin
        in_valid_r <= 1'b0;
      end
      if (proc) begin
        state_r <= state_nxt;
      end
      if (proc && in_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_char_r <= in_tdata[7:0];
      in_last_r <= in_tlast;
    end
    if (proc && in_last_r) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0,
                       out_res_r.bass_pitch,
                       out_res_r.inversion_num,
                       out_res_r.has_dim_seventh,
                       out_res_r.has_major_seventh,
                       out_res_r.has_dom_seventh,
                       out_res_r.is_augmented,
                       out_res_r.is_diminished,
                       out_res_r.is_minor,
                       out_res_r.root_pitch,
                       out_res_r.error_code};

  // an errored chord carries nothing but its code
  `CSP_ASSERT_NOW(a_err_clears_fields, clk, rst_n,
    out_valid_r && out_res_r.error_code != csp_pkg::ERR_NONE, out_tdata[22:4] == 19'd0)

  // error codes stay in the dense range
  `CSP_ASSERT_NOW(a_err_range, clk, rst_n,
    out_valid_r, out_res_r.error_code <= csp_pkg::ERR_TRAILING)

  // the parser is back at its start after each last character
  `CSP_ASSERT_NEXT(a_state_reset, clk, rst_n,
    proc && in_last_r,
    state_r.phase == csp_pkg::PH_START && state_r.err == csp_pkg::ERR_NONE)

  // input backpressure only comes from a blocked result slot
  `CSP_ASSERT_NOW(a_ready_cause, clk, rst_n,
    !in_tready, in_valid_r && in_last_r && out_valid_r && !out_tready)

endmodule

[bench/tb_chord_symbol_parser.sv]
// self-checking testbench for chord_symbol_parser: directed table, then random chord symbols
// holds its own symbol decoder and compares every decoded chord field by field
// depends on csp_pkg and the chord_symbol_parser rtl
module tb_chord_symbol_parser;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_CHARS  = 520;   // random characters per idling phase
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off to back the block up
  localparam int DIR_N        = 26;

  // one row of the directed table; res is used only where typed is set
  typedef struct packed {
    logic [7:0]       ch;
    bit               last;
    bit               typed;
    csp_pkg::result_t res;
  } stim_row_t;

  localparam stim_row_t DIR_TAB [DIR_N] = '{
    // star alone
    '{ch: csp_pkg::CH_STAR, last: 1'b1, typed: 1'b1,
      res: '{error_code: csp_pkg::ERR_ROOT, default: '0}},
    // highest byte where a root is expected
    '{ch: 8'hFF, last: 1'b1, typed: 1'b1,
      res: '{error_code: csp_pkg::ERR_ROOT, default: '0}},
    // second star
    '{ch: csp_pkg::CH_STAR, last: 1'b0, typed: 1'b0, res: '0},
    '{ch: csp_pkg::CH_STAR, last: 1'b1, typed: 1'b1,
      res: '{error_code: csp_pkg::ERR_ROOT, default: '0}},
    // star after the root is a trailing token
    '{ch: csp_pkg::CH_B,    last: 1'b0, typed: 1'b0, res: '0},
    '{ch: csp_pkg::CH_STAR, last: 1'b1, typed: 1'b1,
      res: '{error_code: csp_pkg::ERR_TRAILING, default: '0}},
    // symbol ends on M
    '{ch: csp_pkg::CH_E,    last: 1'b0, typed: 1'b0, res: '0},
    '{ch: csp_pkg::CH_MAJ,  last: 1'b1, typed: 1'b1,
      res: '{error_code: csp_pkg::ERR_M_NO_SEV, default: '0}},
    // c flat: lowest root and bass
    '{ch: csp_pkg::CH_C,    last: 1'b0, typed: 1'b0, res: '0},
    '{ch: csp_pkg::CH_FLAT, last: 1'b1, typed: 1'b1,
      res: '{error_code: csp_pkg::ERR_NONE, root_pitch: -5'sd1, bass_pitch: -6'sd1,
             default: '0}},
    // m with o, then a character that must be ignored
    '{ch: csp_pkg::CH_A,    last: 1'b0, typed: 1'b0, res: '0},
    '{ch: csp_pkg::CH_MIN,  last: 1'b0, typed: 1'b0, res: '0},
    '{ch: csp_pkg::CH_DIM,  last: 1'b0, typed: 1'b0, res: '0},
    '{ch: csp_pkg::CH_G,    last: 1'b1, typed: 1'b1,
      res: '{error_code: csp_pkg::ERR_M_O, default: '0}},
    // b sharp half-diminished, third inversion: highest root
    '{ch: csp_pkg::CH_B,     last: 1'b0, typed: 1'b0, res: '0},
    '{ch: csp_pkg::CH_SHARP, last: 1'b0, typed: 1'b0, res: '0},
    '{ch: csp_pkg::CH_HALF,  last: 1'b0, typed: 1'b0, res: '0},
    '{ch: csp_pkg::CH_INV,   last: 1'b0, typed: 1'b0, res: '0},
    '{ch: csp_pkg::CH_INV,   last: 1'b0, typed: 1'b0, res: '0},
    '{ch: csp_pkg::CH_INV,   last: 1'b1, typed: 1'b0, res: '0},
    // augmented with major seventh, first inversion
    '{ch: csp_pkg::CH_F,    last: 1'b0, typed: 1'b0, res: '0},
    '{ch: csp_pkg::CH_AUG,  last: 1'b0, typed: 1'b0, res: '0},
    '{ch: csp_pkg::CH_MAJ,  last: 1'b0, typed: 1'b0, res: '0},
    '{ch: csp_pkg::CH_SEV,  last: 1'b0, typed: 1'b0, res: '0},
    '{ch: csp_pkg::CH_INV,  last: 1'b1, typed: 1'b0, res: '0},
    // lowest byte where a root is expected
    '{ch: 8'h00, last: 1'b1, typed: 1'b1,
      res: '{error_code: csp_pkg::ERR_ROOT, default: '0}}
  };

  localparam logic [7:0] ROOT_CHARS [7] = '{
    csp_pkg::CH_C, csp_pkg::CH_D, csp_pkg::CH_E, csp_pkg::CH_F, csp_pkg::CH_G,
    csp_pkg::CH_A, csp_pkg::CH_B
  };
  localparam logic [7:0] TOKEN_CHARS [10] = '{
    csp_pkg::CH_STAR, csp_pkg::CH_FLAT, csp_pkg::CH_SHARP, csp_pkg::CH_MIN,
    csp_pkg::CH_DIM, csp_pkg::CH_HALF, csp_pkg::CH_AUG, csp_pkg::CH_MAJ,
    csp_pkg::CH_SEV, csp_pkg::CH_INV
  };

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  chord_symbol_parser DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] symbol_char
    .in_tlast   (in_tlast),    // is_last
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)    // [3:0] error_code ... [22:17] bass_pitch
  );

  // decoder state, mirrors the parse registers of the block
  csp_pkg::phase_t cur_phase;
  csp_pkg::err_t   cur_err;
  int              cur_root;
  csp_pkg::flags_t cur_flags;
  logic [1:0]      cur_inv;

  csp_pkg::result_t chord_q [$];     // decoded chords still to come out
  logic [7:0]       sym_q [$];       // characters of the symbol being built

  int idle_in_pct  = 0;
  int idle_out_pct = 0;
  int rx_hold      = 0;        // receiver hold-off request, counted down by the receiver
  int n_fail       = 0;
  int n_chars      = 0;
  int n_chords     = 0;
  int n_clean      = 0;
  bit [15:0] codes_seen = '0;

  // clock; reset is driven by the main sequence
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- decoder

  function automatic void clear_decoder();
    cur_phase = csp_pkg::PH_START;
    cur_err   = csp_pkg::ERR_NONE;
    cur_root  = 0;
    cur_flags = '0;
    cur_inv   = 2'd0;
  endfunction

  // only the first error of a symbol sticks
  function automatic void latch_err(input csp_pkg::err_t e);
    if (cur_err == csp_pkg::ERR_NONE) cur_err = e;
  endfunction

  // phase in which a token character is allowed, PH_START for a non-token
  function automatic csp_pkg::phase_t token_phase(input logic [7:0] c);
    case (c)
      csp_pkg::CH_FLAT, csp_pkg::CH_SHARP: return csp_pkg::PH_ACC;
      csp_pkg::CH_MIN:  return csp_pkg::PH_M;
      csp_pkg::CH_DIM:  return csp_pkg::PH_O;
      csp_pkg::CH_HALF: return csp_pkg::PH_X;
      csp_pkg::CH_AUG:  return csp_pkg::PH_AUG;
      csp_pkg::CH_MAJ:  return csp_pkg::PH_MAJ;
      csp_pkg::CH_SEV:  return csp_pkg::PH_SEV;
      csp_pkg::CH_INV:  return csp_pkg::PH_INV;
      default:          return csp_pkg::PH_START;
    endcase
  endfunction

  function automatic void take_root(input logic [7:0] c);
    case (c)
      csp_pkg::CH_C: cur_root = 0;
      csp_pkg::CH_D: cur_root = 2;
      csp_pkg::CH_E: cur_root = 4;
      csp_pkg::CH_F: cur_root = 5;
      csp_pkg::CH_G: cur_root = 7;
      csp_pkg::CH_A: cur_root = 9;
      csp_pkg::CH_B: cur_root = 11;
      default: begin
        latch_err(csp_pkg::ERR_ROOT);
        return;
      end
    endcase
    cur_phase = csp_pkg::PH_ACC;
  endfunction

  function automatic void take_token(input logic [7:0] c);
    csp_pkg::phase_t slot;
    slot = token_phase(c);
    if (slot == csp_pkg::PH_START || slot < cur_phase) begin
      latch_err(csp_pkg::ERR_TRAILING);
      return;
    end
    case (slot)
      csp_pkg::PH_ACC: cur_root += (c == csp_pkg::CH_FLAT) ? -1 : 1;
      csp_pkg::PH_M:   cur_flags.minor = 1'b1;
      csp_pkg::PH_O: begin
        if (cur_flags.minor) begin
          latch_err(csp_pkg::ERR_M_O);
          return;
        end
        cur_flags.minor = 1'b1;
        cur_flags.dim   = 1'b1;
      end
      csp_pkg::PH_X: begin
        if (cur_flags.minor) begin
          latch_err(csp_pkg::ERR_M_X);
          return;
        end
        cur_flags.minor = 1'b1;
        cur_flags.dim   = 1'b1;
        cur_flags.dom7  = 1'b1;
        cur_flags.half  = 1'b1;
      end
      csp_pkg::PH_AUG: begin
        if (cur_flags.minor) begin
          latch_err(csp_pkg::ERR_AUG_MINOR);
          return;
        end
        cur_flags.aug = 1'b1;
      end
      csp_pkg::PH_MAJ: begin
        cur_phase = csp_pkg::PH_AFTER_M;
        return;
      end
      csp_pkg::PH_SEV: begin
        if (cur_flags.maj7) begin
          latch_err(csp_pkg::ERR_SEV_MAJ7);
          return;
        end
        if (cur_flags.half) begin
          latch_err(csp_pkg::ERR_SEV_X);
          return;
        end
        if (cur_flags.dim) cur_flags.dim7 = 1'b1;
        else cur_flags.dom7 = 1'b1;
      end
      default: begin
        cur_inv   = 2'd1;
        cur_phase = csp_pkg::PH_INV1;
        return;
      end
    endcase
    cur_phase = csp_pkg::phase_t'(slot + 1);
  endfunction

  function automatic void take_char(input logic [7:0] c);
    case (cur_phase)
      csp_pkg::PH_START: begin
        if (c == csp_pkg::CH_STAR) cur_phase = csp_pkg::PH_ROOT;
        else take_root(c);
      end
      csp_pkg::PH_ROOT: take_root(c);
      csp_pkg::PH_AFTER_M: begin
        if (c == csp_pkg::CH_SEV) begin
          cur_flags.maj7 = 1'b1;
          cur_phase = csp_pkg::PH_SEV;
        end else begin
          latch_err(csp_pkg::ERR_M_NO_SEV);
        end
      end
      csp_pkg::PH_INV1: begin
        if (c == csp_pkg::CH_INV) begin
          cur_inv   = 2'd2;
          cur_phase = csp_pkg::PH_INV2;
        end else begin
          latch_err(csp_pkg::ERR_INV_CHAR);
        end
      end
      csp_pkg::PH_INV2: begin
        if (c != csp_pkg::CH_INV) latch_err(csp_pkg::ERR_INV_CHAR);
        else if (!(cur_flags.dom7 || cur_flags.maj7 || cur_flags.dim7))
          latch_err(csp_pkg::ERR_INV3_TRIAD);
        else begin
          cur_inv   = 2'd3;
          cur_phase = csp_pkg::PH_DONE;
        end
      end
      default: take_token(c);
    endcase
  endfunction

  // advance the decoder by one character; returns 1 with the chord on the last one
  function automatic bit decode_char(input logic [7:0] c, input bit last,
                                     output csp_pkg::result_t r);
    int bass;
    r = '0;
    if (cur_err == csp_pkg::ERR_NONE) take_char(c);
    if (!last) return 1'b0;
    if (cur_phase == csp_pkg::PH_ROOT) latch_err(csp_pkg::ERR_ROOT);
    if (cur_phase == csp_pkg::PH_AFTER_M) latch_err(csp_pkg::ERR_M_NO_SEV);
    r.error_code = cur_err;
    if (cur_err == csp_pkg::ERR_NONE) begin
      // bass note: the root, or the third, fifth or seventh above the root
      bass = cur_root;
      case (cur_inv)
        2'd1: bass += cur_flags.minor ? 3 : 4;
        2'd2: bass += cur_flags.aug ? 8 : (cur_flags.dim ? 6 : 7);
        2'd3: begin
          if (cur_flags.dom7) bass += 10;
          else if (cur_flags.maj7) bass += 11;
          else if (cur_flags.dim7) bass += 9;
        end
        default: ;
      endcase
      r.root_pitch        = cur_root[4:0];
      r.is_minor          = cur_flags.minor;
      r.is_diminished     = cur_flags.dim;
      r.is_augmented      = cur_flags.aug;
      r.has_dom_seventh   = cur_flags.dom7;
      r.has_major_seventh = cur_flags.maj7;
      r.has_dim_seventh   = cur_flags.dim7;
      r.inversion_num     = cur_inv;
      r.bass_pitch        = bass[5:0];
    end
    clear_decoder();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- sender side

  // offer one character, with random idle cycles ahead of it, until it is transferred
  task automatic send_char(input logic [7:0] c, input bit last, input bit typed,
                           input csp_pkg::result_t typed_res);
    csp_pkg::result_t r;
    while ($urandom_range(0, 99) < idle_in_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    n_chars++;
    if (decode_char(c, last, r)) chord_q.push_back(typed ? typed_res : r);
  endtask

  // stop offering and wait until every decoded chord has come out
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (chord_q.size() != 0);
  endtask

  // well-formed symbol with random content; some combinations still give errors
  function automatic void build_clean();
    int n;
    sym_q = {};
    if ($urandom_range(0, 9) == 0) sym_q.push_back(csp_pkg::CH_STAR);
    sym_q.push_back(ROOT_CHARS[$urandom_range(0, 6)]);
    case ($urandom_range(0, 2))
      1: sym_q.push_back(csp_pkg::CH_FLAT);
      2: sym_q.push_back(csp_pkg::CH_SHARP);
      default: ;
    endcase
    case ($urandom_range(0, 4))
      1: sym_q.push_back(csp_pkg::CH_MIN);
      2: sym_q.push_back(csp_pkg::CH_DIM);
      3: sym_q.push_back(csp_pkg::CH_HALF);
      4: sym_q.push_back(csp_pkg::CH_AUG);
      default: ;
    endcase
    case ($urandom_range(0, 2))
      1: begin
        sym_q.push_back(csp_pkg::CH_MAJ);
        sym_q.push_back(csp_pkg::CH_SEV);
      end
      2: sym_q.push_back(csp_pkg::CH_SEV);
      default: ;
    endcase
    n = $urandom_range(0, 3);
    repeat (n) sym_q.push_back(csp_pkg::CH_INV);
  endfunction

  // damage a well-formed symbol: stray token, wrong byte, cut short or dangling M
  function automatic void break_symbol();
    int pos;
    int keep;
    case ($urandom_range(0, 3))
      0: begin
        pos = $urandom_range(0, sym_q.size());
        sym_q.insert(pos, TOKEN_CHARS[$urandom_range(0, 9)]);
      end
      1: begin
        pos = $urandom_range(0, sym_q.size() - 1);
        sym_q[pos] = 8'($urandom_range(0, 255));
      end
      2: begin
        keep = $urandom_range(1, sym_q.size());
        while (sym_q.size() > keep) void'(sym_q.pop_back());
      end
      default: sym_q.push_back(csp_pkg::CH_MAJ);
    endcase
  endfunction

  // short run of tokens, root letters and arbitrary bytes
  function automatic void build_noise();
    int n;
    sym_q = {};
    n = $urandom_range(1, 5);
    repeat (n) begin
      case ($urandom_range(0, 2))
        0: sym_q.push_back(TOKEN_CHARS[$urandom_range(0, 9)]);
        1: sym_q.push_back(ROOT_CHARS[$urandom_range(0, 6)]);
        default: sym_q.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endfunction

  // random symbols until about n_target characters have been transferred
  task automatic send_random(input int n_target);
    int start;
    int pick;
    start = n_chars;
    while (n_chars - start < n_target) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        build_clean();
      end else if (pick < 9) begin
        build_clean();
        break_symbol();
      end else begin
        build_noise();
      end
      foreach (sym_q[k]) send_char(sym_q[k], k == sym_q.size() - 1, 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------- receiver side

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      n_fail++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // checks each result transfer, then drives out_tready for the next cycle
  initial begin
    csp_pkg::result_t want;
    csp_pkg::result_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid === 1'b1 && out_tready) begin
        got.error_code        = csp_pkg::err_t'(out_tdata[3:0]);
        got.root_pitch        = out_tdata[8:4];
        got.is_minor          = out_tdata[9];
        got.is_diminished     = out_tdata[10];
        got.is_augmented      = out_tdata[11];
        got.has_dom_seventh   = out_tdata[12];
        got.has_major_seventh = out_tdata[13];
        got.has_dim_seventh   = out_tdata[14];
        got.inversion_num     = out_tdata[16:15];
        got.bass_pitch        = out_tdata[22:17];
        if (chord_q.size() == 0) begin
          n_fail++;
          $display("%0t: unexpected result transfer, actual tdata %h", $time, out_tdata);
        end else begin
          want = chord_q.pop_front();
          n_chords++;
          codes_seen[want.error_code] = 1'b1;
          if (want.error_code == csp_pkg::ERR_NONE) n_clean++;
          check_field("error_code", want.error_code, got.error_code);
          check_field("root_pitch", $signed(want.root_pitch), $signed(got.root_pitch));
          check_field("is_minor", want.is_minor, got.is_minor);
          check_field("is_diminished", want.is_diminished, got.is_diminished);
          check_field("is_augmented", want.is_augmented, got.is_augmented);
          check_field("has_dom_seventh", want.has_dom_seventh, got.has_dom_seventh);
          check_field("has_major_seventh", want.has_major_seventh, got.has_major_seventh);
          check_field("has_dim_seventh", want.has_dim_seventh, got.has_dim_seventh);
          check_field("inversion_num", want.inversion_num, got.inversion_num);
          check_field("bass_pitch", $signed(want.bass_pitch), $signed(got.bass_pitch));
        end
      end
      // a pending hold-off wins over the random stall
      if (rx_hold > 0) begin
        out_tready <= 1'b0;
        rx_hold--;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= idle_out_pct);
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("** chord_symbol_parser: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------- main sequence

  initial begin
    clear_decoder();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table under light idling on both sides
    idle_in_pct  = 35;
    idle_out_pct = 54;
    foreach (DIR_TAB[i]) send_char(DIR_TAB[i].ch, DIR_TAB[i].last, DIR_TAB[i].typed,
                                   DIR_TAB[i].res);
    drain();

    // sender idles less than the receiver
    send_random(PHASE_CHARS);
    drain();

    // receiver idles less than the sender
    idle_in_pct  = 54;
    idle_out_pct = 35;
    send_random(PHASE_CHARS);
    drain();

    // no idling; a long receiver hold-off first backs the block up into its input
    idle_in_pct  = 0;
    idle_out_pct = 0;
    rx_hold      = HOLD_CYCLES;
    send_random(PHASE_CHARS);
    drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d characters and %0d decoded chords (%0d clean),",
             n_chars, n_chords, n_clean);
    $display("with %0d distinct error codes seen and %0d mismatches",
             $countones(codes_seen[15:1]), n_fail);
    if (n_fail == 0 && chord_q.size() == 0) begin
      $display("** chord_symbol_parser: PASSED **");
    end else begin
      $display("** chord_symbol_parser: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/csp_pkg.sv
sv/csp_step.sv
sv/chord_symbol_parser.sv
bench/tb_chord_symbol_parser.sv
